// ===== rtl/rme_pkg.sv =====
// Shared types and constants of the register machine execute block.
// Used by the controller, the divider, the datapath and the top level.
package rme_pkg;

  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_MOV   = 4'd5;
  localparam logic [3:0] OP_LDI   = 4'd6;
  localparam logic [3:0] OP_JMP   = 4'd7;
  localparam logic [3:0] OP_JZ    = 4'd8;
  localparam logic [3:0] OP_LT    = 4'd9;
  localparam logic [3:0] OP_GT    = 4'd10;
  localparam logic [3:0] OP_EQ    = 4'd11;
  localparam logic [3:0] OP_PRINT = 4'd12;
  localparam logic [3:0] OP_LOAD  = 4'd13;
  localparam logic [3:0] OP_STORE = 4'd14;

  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [3:0]         operation;
    logic [3:0]         dest_reg;
    logic [3:0]         src_reg_a;
    logic [3:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic [4:0]         mem_addr;
    logic [15:0]        jump_target;
    logic [15:0]        line_number;
  } rme_instr_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic div_start;
    logic retire;
  } rme_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_div;
    logic div_done;
    logic out_free;
  } rme_status_t;

endpackage

// ===== rtl/rme_if.sv =====
// Handshake channels of the register machine execute block.
// Input channel carries one decoded instruction, output channel one result.
interface rme_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic [3:0]         dest_reg;
  logic [3:0]         src_reg_a;
  logic [3:0]         src_reg_b;
  logic signed [31:0] immediate;
  logic [4:0]         mem_addr;
  logic [15:0]        jump_target;
  logic [15:0]        line_number;

  modport source (
    output valid, operation, dest_reg, src_reg_a, src_reg_b, immediate, mem_addr,
           jump_target, line_number,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_reg, src_reg_a, src_reg_b, immediate, mem_addr,
           jump_target, line_number,
    output ready
  );
endinterface

interface rme_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_line;
  logic               goes_back;
  logic               printed;
  logic signed [31:0] print_value;

  modport source (
    output valid, next_line, goes_back, printed, print_value,
    input  ready
  );
  modport sink (
    input  valid, next_line, goes_back, printed, print_value,
    output ready
  );
endinterface

// ===== rtl/register_machine_execute_top.sv =====
// Top level of the register machine execute block.
// Depends on rme_pkg, rme_if, rme_ctrl and rme_datapath.
//
// Executes one decoded instruction per input transaction and returns one result
// transaction with the next line, a backward flag and any printed value. After
// reset the block sweeps its register file and data memory to zero over indices
// 0 to max(NUM_REGS, MEM_WORDS) - 1 with in_chan.ready low. One instruction is in
// work at a time: most operations pass through capture with register read, then
// execute and write back; a signed divide also runs the bit-serial divider, which
// retires one quotient bit per cycle. A finished result waits in the output
// register while the next instruction is taken.
module register_machine_execute_top #(
  parameter int NUM_REGS  = 16,
  parameter int MEM_WORDS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rme_in_if.sink     in_chan,
  rme_out_if.source  out_chan
);

  rme_pkg::rme_instr_t  instr;
  rme_pkg::rme_cmd_t    cmd;
  rme_pkg::rme_status_t status;

  assign instr.operation   = in_chan.operation;
  assign instr.dest_reg    = in_chan.dest_reg;
  assign instr.src_reg_a   = in_chan.src_reg_a;
  assign instr.src_reg_b   = in_chan.src_reg_b;
  assign instr.immediate   = in_chan.immediate;
  assign instr.mem_addr    = in_chan.mem_addr;
  assign instr.jump_target = in_chan.jump_target;
  assign instr.line_number = in_chan.line_number;

  rme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rme_datapath #(
    .NUM_REGS  (NUM_REGS),
    .MEM_WORDS (MEM_WORDS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .instr    (instr),
    .cmd      (cmd),
    .status   (status),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/rme_div.sv =====
// Bit-serial signed 32-bit divider, one quotient bit per cycle.
// Depends on rme_pkg for the step count.
module rme_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[31] ? (32'd0 - dividend) : dividend;
      dvs_nxt  = divisor[31] ? (32'd0 - divisor) : divisor;
      neg_nxt  = dividend[31] ^ divisor[31];
      zero_nxt = (divisor == 32'd0);
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(rme_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  assign done     = done_r;
  assign quotient = zero_r ? 32'd0 : (neg_r ? (32'd0 - quo_r) : quo_r);

endmodule

// ===== rtl/rme_ctrl.sv =====
// Controller state machine of the register machine execute block.
// Depends on rme_pkg for the command and status structs.
module rme_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rme_pkg::rme_status_t status,
  output rme_pkg::rme_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else if (status.out_free) begin
          cmd.retire = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status.div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.retire = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/rme_datapath.sv =====
// Datapath: register file, data memory, ALU, divider and result register.
// Depends on rme_pkg, rme_out_if and rme_div.
module rme_datapath #(
  parameter int NUM_REGS  = 16,
  parameter int MEM_WORDS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rme_pkg::rme_instr_t  instr,
  input  rme_pkg::rme_cmd_t    cmd,
  output rme_pkg::rme_status_t status,
  rme_out_if.source            out_chan
);

  localparam int REG_AW = $clog2(NUM_REGS);
  localparam int MEM_AW = $clog2(MEM_WORDS);
  localparam int CLR_N  = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
  localparam int CLR_W  = $clog2(CLR_N);

  logic [31:0] rf  [NUM_REGS];
  logic [31:0] mem [MEM_WORDS];

  logic [CLR_W-1:0]  clr_idx_r;
  logic              clr_reg_ok;
  logic              clr_mem_ok;

  logic [REG_AW-1:0] ra_idx, rb_idx, rd_idx;
  logic [MEM_AW-1:0] addr_idx;

  logic [3:0]        op_r;
  logic [REG_AW-1:0] rd_idx_r;
  logic              rd_ok_r, ra_ok_r, rb_ok_r;
  logic [MEM_AW-1:0] addr_idx_r;
  logic              addr_ok_r;
  logic [31:0]       imm_r;
  logic [15:0]       target_r;
  logic [15:0]       line_r;
  logic [31:0]       rda_r, rdb_r, mrd_r;

  logic [31:0] opa, opb;
  logic [31:0] alu_res;
  logic        alu_we;
  logic [31:0] wdata;
  logic [31:0] div_q;
  logic        div_done;
  logic [15:0] next_line;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_next_r;
  logic        out_back_r;
  logic        out_printed_r;
  logic [31:0] out_pval_r;

  assign ra_idx   = REG_AW'(instr.src_reg_a);
  assign rb_idx   = REG_AW'(instr.src_reg_b);
  assign rd_idx   = REG_AW'(instr.dest_reg);
  assign addr_idx = MEM_AW'(instr.mem_addr);

  assign clr_reg_ok = ({1'b0, clr_idx_r} < (CLR_W + 1)'(NUM_REGS));
  assign clr_mem_ok = ({1'b0, clr_idx_r} < (CLR_W + 1)'(MEM_WORDS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clear && !status.clear_last) begin
      clr_idx_r <= clr_idx_r + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= instr.operation;
      rd_idx_r   <= rd_idx;
      rd_ok_r    <= (int'(instr.dest_reg) < NUM_REGS);
      ra_ok_r    <= (int'(instr.src_reg_a) < NUM_REGS);
      rb_ok_r    <= (int'(instr.src_reg_b) < NUM_REGS);
      addr_idx_r <= addr_idx;
      addr_ok_r  <= (int'(instr.mem_addr) < MEM_WORDS);
      imm_r      <= instr.immediate;
      target_r   <= instr.jump_target;
      line_r     <= instr.line_number;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && clr_reg_ok) begin
      rf[clr_idx_r[REG_AW-1:0]] <= '0;
    end else if (cmd.retire && alu_we && rd_ok_r) begin
      rf[rd_idx_r] <= wdata;
    end
    if (cmd.capture) begin
      rda_r <= rf[ra_idx];
      rdb_r <= rf[rb_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear && clr_mem_ok) begin
      mem[clr_idx_r[MEM_AW-1:0]] <= '0;
    end else if (cmd.retire && op_r == rme_pkg::OP_STORE && addr_ok_r) begin
      mem[addr_idx_r] <= opa;
    end
    if (cmd.capture) begin
      mrd_r <= mem[addr_idx];
    end
  end

  assign opa = ra_ok_r ? rda_r : 32'd0;
  assign opb = rb_ok_r ? rdb_r : 32'd0;

  rme_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    alu_res = '0;
    alu_we  = 1'b0;
    case (op_r)
      rme_pkg::OP_ADD: begin alu_res = opa + opb; alu_we = 1'b1; end
      rme_pkg::OP_MUL: begin alu_res = opa * opb; alu_we = 1'b1; end
      rme_pkg::OP_SUB: begin alu_res = opa - opb; alu_we = 1'b1; end
      rme_pkg::OP_DIV: begin alu_res = div_q; alu_we = 1'b1; end
      rme_pkg::OP_MOV: begin alu_res = opa; alu_we = 1'b1; end
      rme_pkg::OP_LDI: begin alu_res = imm_r; alu_we = 1'b1; end
      rme_pkg::OP_LT: begin
        alu_res = {31'd0, $signed(opa) < $signed(opb)};
        alu_we  = 1'b1;
      end
      rme_pkg::OP_GT: begin
        alu_res = {31'd0, $signed(opa) > $signed(opb)};
        alu_we  = 1'b1;
      end
      rme_pkg::OP_EQ: begin alu_res = {31'd0, opa == opb}; alu_we = 1'b1; end
      rme_pkg::OP_LOAD: begin
        alu_res = addr_ok_r ? mrd_r : 32'd0;
        alu_we  = 1'b1;
      end
      default: begin
        alu_res = '0;
        alu_we  = 1'b0;
      end
    endcase
  end

  assign wdata = alu_res;

  always_comb begin
    next_line = line_r + 16'd1;
    if (op_r == rme_pkg::OP_JMP || (op_r == rme_pkg::OP_JZ && opa == 32'd0)) begin
      next_line = target_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    if (cmd.retire) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.retire) begin
      out_next_r    <= next_line;
      out_back_r    <= (next_line <= line_r);
      out_printed_r <= (op_r == rme_pkg::OP_PRINT);
      out_pval_r    <= (op_r == rme_pkg::OP_PRINT) ? opa : 32'd0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.next_line   = out_next_r;
  assign out_chan.goes_back   = out_back_r;
  assign out_chan.printed     = out_printed_r;
  assign out_chan.print_value = out_pval_r;

  assign status.clear_last = (clr_idx_r == CLR_W'(CLR_N - 1));
  assign status.is_div     = (op_r == rme_pkg::OP_DIV);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid_r || out_chan.ready;

endmodule

// ===== rtl/rme_checker.sv =====
// Port-level checks of the register machine execute block.
// Bound to register_machine_execute_top; sees only its ports.
module rme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_next_line,
  input logic        out_goes_back,
  input logic        out_printed,
  input logic [31:0] out_print_value
);

  logic [1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready) pend_nxt = pend_nxt + 2'd1;
    if (out_valid && out_ready) pend_nxt = pend_nxt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_next_line, out_goes_back, out_printed, out_print_value}))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted instruction");

  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> pend_r == 2'd0 || pend_r == 2'd1)
    else $error("instruction taken with too many in flight");

  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_printed |-> out_print_value == 32'd0)
    else $error("print value set without print");

endmodule

bind register_machine_execute_top rme_checker u_rme_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_next_line   (out_chan.next_line),
  .out_goes_back   (out_chan.goes_back),
  .out_printed     (out_chan.printed),
  .out_print_value (out_chan.print_value)
);
